>>> src/tcef_pkg.sv
// ----------------------------------------------------------------------------
// tcef_pkg
// shared types, sizes and codes of the timer coalescing event fifo
// ----------------------------------------------------------------------------
`default_nettype none

package tcef_pkg;

    // fifo storage
    localparam int FIFO_DEPTH = 64;
    localparam int ADDR_W     = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // item fields
    localparam int TYPE_W = 3;
    localparam int KEY_W  = 6;
    localparam int DATA_W = 16;
    localparam int COPY_W = 8;
    localparam int OCC_W  = 7;

    // every key value has a pending mark
    localparam int KEY_COUNT = 1 << KEY_W;

    // event type codes
    localparam logic [TYPE_W-1:0] EV_TIMER = 3'd3;

    // item kind codes
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    typedef struct packed {
        logic [TYPE_W-1:0] ev_type;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
    } entry_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } ram_ctrl_t;

    function automatic logic [ADDR_W-1:0] next_ptr(input logic [ADDR_W-1:0] p);
        logic [ADDR_W-1:0] n;
        if (p == ADDR_W'(FIFO_DEPTH - 1))
            n = '0;
        else
            n = p + ADDR_W'(1);
        return n;
    endfunction

endpackage

`default_nettype wire

>>> src/tcef_if.sv
// ----------------------------------------------------------------------------
// tcef_if
// valid/ready channels for request and response items
// ----------------------------------------------------------------------------
`default_nettype none

interface tcef_req_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [tcef_pkg::TYPE_W-1:0]  event_type;
    logic [tcef_pkg::KEY_W-1:0]   ev_key;
    logic [tcef_pkg::DATA_W-1:0]  extra_data;
    logic [tcef_pkg::COPY_W-1:0]  copy_count;

    modport source (
        output valid, kind, event_type, ev_key, extra_data, copy_count,
        input  ready
    );
    modport sink (
        input  valid, kind, event_type, ev_key, extra_data, copy_count,
        output ready
    );
endinterface

interface tcef_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         popped;
    logic [tcef_pkg::TYPE_W-1:0]  out_type;
    logic [tcef_pkg::KEY_W-1:0]   out_key;
    logic [tcef_pkg::DATA_W-1:0]  out_data;
    logic                         overflow;
    logic [tcef_pkg::OCC_W-1:0]   occupancy;

    modport source (
        output valid, popped, out_type, out_key, out_data, overflow, occupancy,
        input  ready
    );
    modport sink (
        input  valid, popped, out_type, out_key, out_data, overflow, occupancy,
        output ready
    );
endinterface

`default_nettype wire

>>> src/timer_coalescing_event_fifo.sv
// ----------------------------------------------------------------------------
// timer_coalescing_event_fifo
// event fifo that keeps at most one pending timer entry per key
// ----------------------------------------------------------------------------
// Each request item is an enqueue or a dequeue and gives exactly one response
// item. An enqueue of a non-timer event writes copy_count copies, one per
// cycle, through the single write port of the entry ram; copies that find the
// fifo full are dropped and flagged as overflow. A timer enqueue writes one
// entry only when its key has no timer entry waiting, and marks the key. A
// dequeue reads the head entry through the registered ram read port and frees
// the key's mark if the entry is a timer. One item is worked on at a time;
// once accepted, an enqueue writes its copies in the push state, which a full
// fifo ends, and a dequeue of a non-empty fifo takes the head entry in the
// read state; an enqueue with no copies, a coalesced timer or a dequeue of an
// empty fifo goes straight to the done state. The done state loads the
// response register once its consumer has taken the last response.
// The next item is accepted the cycle after the response is loaded, even if
// that response still waits for its consumer. Pending marks are cleared by
// reset; the entry ram needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module timer_coalescing_event_fifo (
    input  wire logic clk,
    input  wire logic rst_n,
    tcef_req_if.sink  req,
    tcef_rsp_if.source rsp
);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PUSH = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg, state_next;

    // fifo bookkeeping
    logic [tcef_pkg::ADDR_W-1:0] head_reg, head_next;
    logic [tcef_pkg::ADDR_W-1:0] tail_reg, tail_next;
    logic [tcef_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [tcef_pkg::KEY_COUNT-1:0] pending_reg, pending_next;

    // latched request
    tcef_pkg::entry_t            item_reg, item_next;
    logic [tcef_pkg::COPY_W-1:0] remain_reg, remain_next;

    // result being built
    logic                        res_has_reg, res_has_next;
    tcef_pkg::entry_t            res_entry_reg, res_entry_next;
    logic                        res_ovf_reg, res_ovf_next;

    // response register
    logic                        out_valid_reg, out_valid_next;
    logic                        out_has_reg, out_has_next;
    tcef_pkg::entry_t            out_entry_reg, out_entry_next;
    logic                        out_ovf_reg, out_ovf_next;
    logic [tcef_pkg::OCC_W-1:0]  out_occ_reg, out_occ_next;

    tcef_pkg::ram_ctrl_t ram_ctrl;
    tcef_pkg::entry_t    ram_rd_data;

    logic req_fire;
    logic fifo_full;
    logic out_free;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign fifo_full = (count_reg == tcef_pkg::CNT_W'(tcef_pkg::FIFO_DEPTH));
    assign out_free  = !out_valid_reg || rsp.ready;

    tcef_ram u_ram (
        .clk     (clk),
        .ctrl    (ram_ctrl),
        .wr_data (item_reg),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        pending_next   = pending_reg;
        item_next      = item_reg;
        remain_next    = remain_reg;
        res_has_next   = res_has_reg;
        res_entry_next = res_entry_reg;
        res_ovf_next   = res_ovf_reg;
        out_valid_next = out_valid_reg;
        out_has_next   = out_has_reg;
        out_entry_next = out_entry_reg;
        out_ovf_next   = out_ovf_reg;
        out_occ_next   = out_occ_reg;
        ram_ctrl       = '0;
        ram_ctrl.wr_addr = tail_reg;
        ram_ctrl.rd_addr = head_reg;

        // consumer takes the response
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    item_next.ev_type = req.event_type;
                    item_next.key     = req.ev_key;
                    item_next.data    = req.extra_data;
                    res_has_next      = 1'b0;
                    res_entry_next    = '0;
                    res_ovf_next      = 1'b0;
                    if (req.kind == tcef_pkg::KIND_DEQ)
                    begin
                        if (count_reg != '0)
                        begin
                            // fetch head, result appears next cycle
                            ram_ctrl.rd_en = 1'b1;
                            head_next      = tcef_pkg::next_ptr(head_reg);
                            count_next     = count_reg - tcef_pkg::CNT_W'(1);
                            state_next     = S_READ;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else if (req.event_type == tcef_pkg::EV_TIMER)
                    begin
                        // coalesce: one entry per key while one is waiting
                        if (req.copy_count != '0 && !pending_reg[req.ev_key])
                        begin
                            remain_next = tcef_pkg::COPY_W'(1);
                            state_next  = S_PUSH;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else if (req.copy_count != '0)
                    begin
                        remain_next = req.copy_count;
                        state_next  = S_PUSH;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_PUSH:
            begin
                if (fifo_full)
                begin
                    // remaining copies are dropped
                    res_ovf_next = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    ram_ctrl.wr_en = 1'b1;
                    tail_next      = tcef_pkg::next_ptr(tail_reg);
                    count_next     = count_reg + tcef_pkg::CNT_W'(1);
                    remain_next    = remain_reg - tcef_pkg::COPY_W'(1);
                    if (item_reg.ev_type == tcef_pkg::EV_TIMER)
                    begin
                        pending_next[item_reg.key] = 1'b1;
                    end
                    if (remain_reg == tcef_pkg::COPY_W'(1))
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_READ:
            begin
                res_has_next   = 1'b1;
                res_entry_next = ram_rd_data;
                if (ram_rd_data.ev_type == tcef_pkg::EV_TIMER)
                begin
                    pending_next[ram_rd_data.key] = 1'b0;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_has_next   = res_has_reg;
                    out_entry_next = res_entry_reg;
                    out_ovf_next   = res_ovf_reg;
                    out_occ_next   = tcef_pkg::OCC_W'(count_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        remain_reg    <= remain_next;
        res_has_reg   <= res_has_next;
        res_entry_reg <= res_entry_next;
        res_ovf_reg   <= res_ovf_next;
        out_has_reg   <= out_has_next;
        out_entry_reg <= out_entry_next;
        out_ovf_reg   <= out_ovf_next;
        out_occ_reg   <= out_occ_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.popped    = out_has_reg;
    assign rsp.out_type  = out_entry_reg.ev_type;
    assign rsp.out_key   = out_entry_reg.key;
    assign rsp.out_data  = out_entry_reg.data;
    assign rsp.overflow  = out_ovf_reg;
    assign rsp.occupancy = out_occ_reg;

`ifndef SYNTH
    // fill level never exceeds the storage
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= tcef_pkg::CNT_W'(tcef_pkg::FIFO_DEPTH))
        else $error("fill count beyond fifo depth");

    // no write into a full fifo
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_ctrl.wr_en |-> !fifo_full)
        else $error("entry written while fifo full");

    // tail runs ahead of head by the fill count
    assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg == tcef_pkg::ADDR_W'(head_reg + tcef_pkg::ADDR_W'(count_reg)))
        else $error("pointers disagree with fill count");

    // a head read follows a one-entry pop
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && req_fire && req.kind == tcef_pkg::KIND_DEQ
            && count_reg != '0) |=> (state_reg == S_READ
            && count_reg == $past(count_reg) - tcef_pkg::CNT_W'(1)))
        else $error("dequeue did not pop exactly one entry");
`endif

endmodule

`default_nettype wire

>>> src/tcef_ram.sv
// ----------------------------------------------------------------------------
// tcef_ram
// entry storage, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module tcef_ram (
    input  wire logic               clk,
    input  wire tcef_pkg::ram_ctrl_t ctrl,
    input  wire tcef_pkg::entry_t   wr_data,
    output tcef_pkg::entry_t        rd_data
);

    tcef_pkg::entry_t mem [tcef_pkg::FIFO_DEPTH];
    tcef_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[ctrl.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the timer coalescing event fifo
// ----------------------------------------------------------------------------
// A table of directed request items goes first. It covers the empty dequeue,
// timer coalescing on a pending key, zero copy counts, a full fifo with
// dropped copies, and the spare type codes. About 780 random items follow in
// four phases of idling and stalls. Every response item is checked field by
// field against its typed directed row's result or an in-bench model of the
// fifo and its timer marks. Early in the run the response side holds off for
// a long stretch so that the block backs up and stalls its request side.
// ----------------------------------------------------------------------------

module tb;

    // sizes from the package
    localparam int TYPE_W     = tcef_pkg::TYPE_W;
    localparam int KEY_W      = tcef_pkg::KEY_W;
    localparam int DATA_W     = tcef_pkg::DATA_W;
    localparam int COPY_W     = tcef_pkg::COPY_W;
    localparam int OCC_W      = tcef_pkg::OCC_W;
    localparam int FIFO_DEPTH = tcef_pkg::FIFO_DEPTH;
    localparam int KEY_COUNT  = tcef_pkg::KEY_COUNT;

    // event type codes besides the timer code from the package
    localparam logic [TYPE_W-1:0] EV_SUBSCRIPTION = 3'd0;
    localparam logic [TYPE_W-1:0] EV_SERVICE      = 3'd1;
    localparam logic [TYPE_W-1:0] EV_CLIENT       = 3'd2;
    localparam logic [TYPE_W-1:0] EV_WAITABLE     = 3'd4;
    localparam logic [TYPE_W-1:0] EV_SPARE5       = 3'd5;
    localparam logic [TYPE_W-1:0] EV_SPARE6       = 3'd6;
    localparam logic [TYPE_W-1:0] EV_SPARE7       = 3'd7;

    localparam int  CLK_PERIOD   = 10;
    localparam int  CYCLE_LIMIT  = 600_000;
    localparam int  LONG_HOLD    = 300;
    localparam int  PHASE_ITEMS  = 195;
    // longest job of the block writes 64 copies plus its overhead states
    localparam int  TAIL_CYCLES  = 100;
    localparam int  PRINT_CAP    = 60;
    localparam int  NUM_DIRECTED = 22;
    localparam bit  TYPED        = 1'b1;
    localparam bit  PREDICTED    = 1'b0;

    typedef struct packed {
        logic              kind;
        logic [TYPE_W-1:0] ev_type;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
        logic [COPY_W-1:0] copies;
    } req_item_t;

    typedef struct packed {
        logic              popped;
        logic [TYPE_W-1:0] ev_type;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
        logic              overflow;
        logic [OCC_W-1:0]  occupancy;
    } rsp_item_t;

    typedef struct packed {
        req_item_t stim;
        logic      typed;
        rsp_item_t result;
    } dir_row_t;

    logic clk;
    logic rst_n;

    tcef_req_if req_ch ();
    tcef_rsp_if rsp_ch ();

    timer_coalescing_event_fifo u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // ------------------------------------------------------------------
    // fifo model: entry ring, pointers, fill count and timer marks
    // ------------------------------------------------------------------
    tcef_pkg::entry_t ring [FIFO_DEPTH];
    int               ring_head;
    int               ring_tail;
    int               ring_fill;
    bit               timer_marked [KEY_COUNT];

    // responses still owed by the block, oldest first
    rsp_item_t owed_rsps [$];

    int fail_count;
    int idle_pct;
    int stall_pct;
    int hold_request;

    // directed items; typed rows carry a result read straight off the spec,
    // the rest are predicted
    dir_row_t directed_rows [NUM_DIRECTED] = '{
        // dequeue on an empty fifo
        '{'{tcef_pkg::KIND_DEQ, EV_SUBSCRIPTION, 6'd0, 16'h0000, 8'd0}, TYPED,
          '{1'b0, 3'd0, 6'd0, 16'h0000, 1'b0, 7'd0}},
        // timer with zero copies pushes nothing
        '{'{tcef_pkg::KIND_ENQ, tcef_pkg::EV_TIMER, 6'd0, 16'h0000, 8'd0}, TYPED,
          '{1'b0, 3'd0, 6'd0, 16'h0000, 1'b0, 7'd0}},
        '{'{tcef_pkg::KIND_ENQ, EV_SUBSCRIPTION, 6'd63, 16'hffff, 8'd1}, TYPED,
          '{1'b0, 3'd0, 6'd0, 16'h0000, 1'b0, 7'd1}},
        '{'{tcef_pkg::KIND_ENQ, tcef_pkg::EV_TIMER, 6'd5, 16'h1234, 8'd1}, TYPED,
          '{1'b0, 3'd0, 6'd0, 16'h0000, 1'b0, 7'd2}},
        // same timer key while pending: coalesced away
        '{'{tcef_pkg::KIND_ENQ, tcef_pkg::EV_TIMER, 6'd5, 16'hbeef, 8'd7}, TYPED,
          '{1'b0, 3'd0, 6'd0, 16'h0000, 1'b0, 7'd2}},
        // non-timer with zero copies
        '{'{tcef_pkg::KIND_ENQ, EV_SERVICE, 6'd0, 16'h0000, 8'd0}, TYPED,
          '{1'b0, 3'd0, 6'd0, 16'h0000, 1'b0, 7'd2}},
        '{'{tcef_pkg::KIND_DEQ, EV_SUBSCRIPTION, 6'd0, 16'h0000, 8'd0}, TYPED,
          '{1'b1, EV_SUBSCRIPTION, 6'd63, 16'hffff, 1'b0, 7'd1}},
        // popping the timer frees key 5
        '{'{tcef_pkg::KIND_DEQ, EV_SUBSCRIPTION, 6'd0, 16'h0000, 8'd0}, TYPED,
          '{1'b1, tcef_pkg::EV_TIMER, 6'd5, 16'h1234, 1'b0, 7'd0}},
        '{'{tcef_pkg::KIND_ENQ, tcef_pkg::EV_TIMER, 6'd5, 16'haaaa, 8'd255}, TYPED,
          '{1'b0, 3'd0, 6'd0, 16'h0000, 1'b0, 7'd1}},
        '{'{tcef_pkg::KIND_ENQ, EV_CLIENT, 6'd1, 16'h5555, 8'd62}, TYPED,
          '{1'b0, 3'd0, 6'd0, 16'h0000, 1'b0, 7'd63}},
        // only one of three copies fits
        '{'{tcef_pkg::KIND_ENQ, EV_WAITABLE, 6'd2, 16'h0001, 8'd3}, TYPED,
          '{1'b0, 3'd0, 6'd0, 16'h0000, 1'b1, 7'd64}},
        // timer into a full fifo: dropped, key 9 stays unmarked
        '{'{tcef_pkg::KIND_ENQ, tcef_pkg::EV_TIMER, 6'd9, 16'h2222, 8'd1}, TYPED,
          '{1'b0, 3'd0, 6'd0, 16'h0000, 1'b1, 7'd64}},
        '{'{tcef_pkg::KIND_ENQ, EV_SPARE7, 6'd3, 16'h7777, 8'd255}, TYPED,
          '{1'b0, 3'd0, 6'd0, 16'h0000, 1'b1, 7'd64}},
        '{'{tcef_pkg::KIND_DEQ, EV_SPARE7, 6'd63, 16'hffff, 8'd255}, TYPED,
          '{1'b1, tcef_pkg::EV_TIMER, 6'd5, 16'haaaa, 1'b0, 7'd63}},
        // spare type codes are stored as given
        '{'{tcef_pkg::KIND_ENQ, EV_SPARE5, 6'd10, 16'h8000, 8'd1}, TYPED,
          '{1'b0, 3'd0, 6'd0, 16'h0000, 1'b0, 7'd64}},
        '{'{tcef_pkg::KIND_DEQ, EV_SUBSCRIPTION, 6'd0, 16'h0000, 8'd0}, TYPED,
          '{1'b1, EV_CLIENT, 6'd1, 16'h5555, 1'b0, 7'd63}},
        '{'{tcef_pkg::KIND_ENQ, tcef_pkg::EV_TIMER, 6'd9, 16'h0f0f, 8'd128}, TYPED,
          '{1'b0, 3'd0, 6'd0, 16'h0000, 1'b0, 7'd64}},
        '{'{tcef_pkg::KIND_ENQ, tcef_pkg::EV_TIMER, 6'd5, 16'h3333, 8'd1}, TYPED,
          '{1'b0, 3'd0, 6'd0, 16'h0000, 1'b1, 7'd64}},
        '{'{tcef_pkg::KIND_DEQ, EV_SUBSCRIPTION, 6'd0, 16'h0000, 8'd0}, PREDICTED,
          '0},
        '{'{tcef_pkg::KIND_ENQ, EV_SPARE6, 6'd40, 16'h8001, 8'd2}, PREDICTED, '0},
        '{'{tcef_pkg::KIND_DEQ, EV_SUBSCRIPTION, 6'd0, 16'h0000, 8'd0}, PREDICTED,
          '0},
        // key 9 now pending: coalesced
        '{'{tcef_pkg::KIND_ENQ, tcef_pkg::EV_TIMER, 6'd9, 16'h0000, 8'd1}, PREDICTED,
          '0}
    };

    // ------------------------------------------------------------------
    // clock and the single reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(CYCLE_LIMIT * CLK_PERIOD);
        $display("timer_coalescing_event_fifo verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // model of the fifo
    // ------------------------------------------------------------------
    function automatic bit ring_push(input req_item_t it);
        if (ring_fill >= FIFO_DEPTH)
            return 1'b0;
        ring[ring_tail] = '{ev_type: it.ev_type, key: it.key, data: it.data};
        ring_tail = (ring_tail + 1) % FIFO_DEPTH;
        ring_fill++;
        return 1'b1;
    endfunction

    // applies one accepted request item to the model, returns its response
    function automatic rsp_item_t coalesce_predict(input req_item_t it);
        rsp_item_t        r;
        tcef_pkg::entry_t head;
        int               n;
        r = '0;
        if (it.kind == tcef_pkg::KIND_ENQ)
        begin
            if (it.ev_type == tcef_pkg::EV_TIMER)
            begin
                // one entry per key until it is popped
                if (it.copies != 0 && !timer_marked[it.key])
                begin
                    if (ring_push(it))
                        timer_marked[it.key] = 1'b1;
                    else
                        r.overflow = 1'b1;
                end
            end
            else
            begin
                for (n = 0; n < int'(it.copies) && !r.overflow; n++)
                    if (!ring_push(it))
                        r.overflow = 1'b1;
            end
        end
        else if (ring_fill != 0)
        begin
            head = ring[ring_head];
            ring_head = (ring_head + 1) % FIFO_DEPTH;
            ring_fill--;
            r.popped  = 1'b1;
            r.ev_type = head.ev_type;
            r.key     = head.key;
            r.data    = head.data;
            if (head.ev_type == tcef_pkg::EV_TIMER)
                timer_marked[head.key] = 1'b0;
        end
        r.occupancy = OCC_W'(ring_fill);
        return r;
    endfunction

    // random request item, biased by fill so the fifo sweeps empty to full
    function automatic req_item_t draw_item();
        req_item_t it;
        int        deq_pct;
        int        pick;
        deq_pct = (ring_fill > 40) ? 65 : (ring_fill < 4) ? 25 : 50;
        it.kind = ($urandom_range(99) < deq_pct) ? tcef_pkg::KIND_DEQ
                                                 : tcef_pkg::KIND_ENQ;
        // timers are frequent and mostly on a few keys, so coalescing hits
        if ($urandom_range(99) < 40)
        begin
            it.ev_type = tcef_pkg::EV_TIMER;
            it.key = ($urandom_range(99) < 70) ? KEY_W'($urandom_range(7))
                                               : KEY_W'($urandom_range(63));
        end
        else
        begin
            it.ev_type = TYPE_W'($urandom_range(7));
            it.key     = KEY_W'($urandom_range(63));
        end
        it.data = DATA_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 70)
            it.copies = COPY_W'($urandom_range(3));
        else if (pick < 90)
            it.copies = COPY_W'($urandom_range(20, 4));
        else
            it.copies = COPY_W'($urandom_range(255));
        return it;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    task automatic offer_item(input req_item_t it, input bit typed,
                              input rsp_item_t typed_rsp);
        rsp_item_t predicted;
        // optional gap before the item, valid dropped only when idling
        if ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= it.kind;
        req_ch.event_type <= it.ev_type;
        req_ch.ev_key     <= it.key;
        req_ch.extra_data <= it.data;
        req_ch.copy_count <= it.copies;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        // accepted at this edge
        predicted = coalesce_predict(it);
        owed_rsps.push_back(typed ? typed_rsp : predicted);
    endtask

    // drop valid and hold until every owed response is back
    task automatic pause_until_drained();
        req_ch.valid <= 1'b0;
        while (owed_rsps.size() != 0)
            @(posedge clk);
    endtask

    task automatic note_mismatch(input string what, input int want, input int got);
        if (fail_count < PRINT_CAP)
            $display("%0t ns: %s mismatch, expected 0x%0h got 0x%0h",
                     $time, what, want, got);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // response side: random stalls plus an occasional long hold-off
    // ------------------------------------------------------------------
    initial
    begin : rsp_driver
        int hold_left;
        hold_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // compare each accepted response item with the oldest owed one
    always @(posedge clk)
    begin : rsp_checker
        rsp_item_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (owed_rsps.size() == 0)
            begin
                note_mismatch("unexpected response, occupancy", 0, rsp_ch.occupancy);
            end
            else
            begin
                want = owed_rsps.pop_front();
                if (rsp_ch.popped !== want.popped)
                    note_mismatch("popped", want.popped, rsp_ch.popped);
                if (rsp_ch.out_type !== want.ev_type)
                    note_mismatch("out_type", want.ev_type, rsp_ch.out_type);
                if (rsp_ch.out_key !== want.key)
                    note_mismatch("out_key", want.key, rsp_ch.out_key);
                if (rsp_ch.out_data !== want.data)
                    note_mismatch("out_data", want.data, rsp_ch.out_data);
                if (rsp_ch.overflow !== want.overflow)
                    note_mismatch("overflow", want.overflow, rsp_ch.overflow);
                if (rsp_ch.occupancy !== want.occupancy)
                    note_mismatch("occupancy", want.occupancy, rsp_ch.occupancy);
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int phase;
        int i;
        fail_count   = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_request = 0;
        ring_head    = 0;
        ring_tail    = 0;
        ring_fill    = 0;
        foreach (timer_marked[k])
            timer_marked[k] = 1'b0;

        req_ch.valid      = 1'b0;
        req_ch.kind       = tcef_pkg::KIND_ENQ;
        req_ch.event_type = '0;
        req_ch.ev_key     = '0;
        req_ch.extra_data = '0;
        req_ch.copy_count = '0;

        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        // directed table, no idling
        for (i = 0; i < NUM_DIRECTED; i++)
            offer_item(directed_rows[i].stim, directed_rows[i].typed,
                       directed_rows[i].result);
        pause_until_drained();

        // random phases: none, sender idle, receiver stalls, both
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 49;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 49;
                end
                default:
                begin
                    idle_pct  = 33;
                    stall_pct = 33;
                end
            endcase
            // long hold-off early on while items keep being offered
            if (phase == 0)
                hold_request = LONG_HOLD;
            for (i = 0; i < PHASE_ITEMS; i++)
                offer_item(draw_item(), PREDICTED, '0);
            pause_until_drained();
        end

        // catch late or spurious responses
        stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (owed_rsps.size() != 0)
            note_mismatch("responses left owed", 0, owed_rsps.size());

        if (fail_count == 0)
            $display("timer_coalescing_event_fifo verification clean");
        else
            $display("timer_coalescing_event_fifo verification failed");
        $finish;
    end

endmodule
